>>> hdl/stcl_pkg.sv
// Shared constants and types for the 3x3 stencil grid update block.
package stcl_pkg;

    localparam int MAX_COLS_DEF       = 1024;
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 14;

    localparam int COEF_BITS      = 16;
    localparam int MASK_BITS      = 3 * COEF_BITS;
    localparam int NUM_COLS_BITS  = 11;
    localparam int ROW_BITS       = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int NUM_TAPS       = 9;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_NUM_COLS    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NUM_ROWS    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MASK_TOP    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MASK_MIDDLE = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MASK_BOTTOM = 3'd4;

    localparam logic [NUM_COLS_BITS-1:0] NUM_COLS_RST    = 11'd500;
    localparam logic [ROW_BITS-1:0]      NUM_ROWS_RST    = 16'd500;
    localparam logic [MASK_BITS-1:0]     MASK_TOP_RST    = 48'd107347968;
    localparam logic [MASK_BITS-1:0]     MASK_MIDDLE_RST = 48'd7035800651366;
    localparam logic [MASK_BITS-1:0]     MASK_BOTTOM_RST = 48'd107347968;

    typedef struct packed {
        logic [MASK_BITS-1:0] top;
        logic [MASK_BITS-1:0] middle;
        logic [MASK_BITS-1:0] bottom;
    } t_mask;

endpackage

>>> hdl/stencil_3x3_grid_update_top.sv
// Top level of the 3x3 stencil grid update block with its configuration registers.
//
// Grid samples enter row-major through the push/full queue port, one beat per
// cycle while full is low; frame_start on a beat restarts at row 0, column 0.
// Each interior point yields one result beat on the empty/pop port holding the
// rounded, saturated weighted sum and the point's row and column; frame_last
// marks the last interior point of a frame. Border samples give no result.
// Throughput is one sample per cycle while full stays low. A result passes, after
// the sample that completes its window is accepted, through the window stage,
// which also reads the line stores, then the queue, then the product, row sum and
// total registers before the saturated output register loads.
// When the receiver stops popping, the result register holds, the arithmetic
// pipeline freezes, and the four-entry queue between window and arithmetic
// fills before full rises toward the sender.
// Configuration writes use the always-ready valid/ready port; the user must make
// them only while the block is idle, as the block itself does not enforce it.
// Reset restores the default grid size and diffusion mask and the position and
// window; the line stores are not cleared, and there is no clearing pass.
module stencil_3x3_grid_update_top #(
    parameter int MAX_COLS       = stcl_pkg::MAX_COLS_DEF,
    parameter int SAMPLE_BITS    = stcl_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = stcl_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample,
    input  logic                                  i_frame_start,
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [SAMPLE_BITS-1:0]         o_value,
    output logic [stcl_pkg::ROW_BITS-1:0]         o_row_index,
    output logic [$clog2(MAX_COLS)-1:0]           o_col_index,
    output logic                                  o_frame_last,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [stcl_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [stcl_pkg::MASK_BITS-1:0]        i_cfg_data
);

    localparam int COL_BITS = $clog2(MAX_COLS);
    localparam int CNT_W    = COL_BITS + 1;
    localparam int RB       = stcl_pkg::ROW_BITS;
    localparam int Q_WIDTH  = stcl_pkg::NUM_TAPS * SAMPLE_BITS + RB + COL_BITS + 1;

    function automatic logic [CNT_W-1:0] clamp_cols(input logic [stcl_pkg::NUM_COLS_BITS-1:0] v);
        logic [31:0] t;
        t = {{(32 - stcl_pkg::NUM_COLS_BITS){1'b0}}, v};
        if (t < 32'd3) begin
            t = 32'd3;
        end else if (t > 32'(MAX_COLS)) begin
            t = 32'(MAX_COLS);
        end
        return t[CNT_W-1:0];
    endfunction

    function automatic logic [RB-1:0] clamp_rows(input logic [RB-1:0] v);
        return (v < RB'(3)) ? RB'(3) : v;
    endfunction

    logic [CNT_W-1:0]      r_cols;
    logic [RB-1:0]         r_rows;
    stcl_pkg::t_mask       r_mask;
    logic                  w_cfg_we;
    logic                  w_q_push;
    logic [Q_WIDTH-1:0]    w_q_wdata;
    logic                  w_q_full;
    logic                  w_q_pop;
    logic [Q_WIDTH-1:0]    w_q_rdata;
    logic                  w_q_empty;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols        <= clamp_cols(stcl_pkg::NUM_COLS_RST);
            r_rows        <= clamp_rows(stcl_pkg::NUM_ROWS_RST);
            r_mask.top    <= stcl_pkg::MASK_TOP_RST;
            r_mask.middle <= stcl_pkg::MASK_MIDDLE_RST;
            r_mask.bottom <= stcl_pkg::MASK_BOTTOM_RST;
        end else if (w_cfg_we) begin
            unique case (i_cfg_index)
                stcl_pkg::CFG_NUM_COLS: begin
                    r_cols <= clamp_cols(i_cfg_data[stcl_pkg::NUM_COLS_BITS-1:0]);
                end
                stcl_pkg::CFG_NUM_ROWS: begin
                    r_rows <= clamp_rows(i_cfg_data[RB-1:0]);
                end
                stcl_pkg::CFG_MASK_TOP: begin
                    r_mask.top <= i_cfg_data;
                end
                stcl_pkg::CFG_MASK_MIDDLE: begin
                    r_mask.middle <= i_cfg_data;
                end
                stcl_pkg::CFG_MASK_BOTTOM: begin
                    r_mask.bottom <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    stcl_front #(
        .MAX_COLS    (MAX_COLS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_sample      (i_sample),
        .i_frame_start (i_frame_start),
        .i_cols        (r_cols),
        .i_rows        (r_rows),
        .o_q_push      (w_q_push),
        .o_q_data      (w_q_wdata),
        .i_q_full      (w_q_full)
    );

    stcl_fifo #(
        .WIDTH (Q_WIDTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_empty (w_q_empty)
    );

    stcl_back #(
        .MAX_COLS       (MAX_COLS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mask       (r_mask),
        .i_q_data     (w_q_rdata),
        .i_q_empty    (w_q_empty),
        .o_q_pop      (w_q_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_value      (o_value),
        .o_row_index  (o_row_index),
        .o_col_index  (o_col_index),
        .o_frame_last (o_frame_last)
    );

endmodule

>>> hdl/stcl_fifo.sv
// Short register queue that decouples the window front end from the arithmetic back end.
module stcl_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int DEPTH = stcl_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == (PTR_W + 1)'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> hdl/stcl_front.sv
// Front end: grid position tracking, line stores, 3x3 window and interior classification.
module stcl_front #(
    parameter int MAX_COLS    = stcl_pkg::MAX_COLS_DEF,
    parameter int SAMPLE_BITS = stcl_pkg::SAMPLE_BITS_DEF,
    parameter int COL_BITS    = $clog2(MAX_COLS),
    parameter int CNT_W       = COL_BITS + 1,
    parameter int Q_WIDTH     = stcl_pkg::NUM_TAPS * SAMPLE_BITS + stcl_pkg::ROW_BITS
                                + COL_BITS + 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    output logic                             o_full,
    input  logic signed [SAMPLE_BITS-1:0]    i_sample,
    input  logic                             i_frame_start,
    input  logic [CNT_W-1:0]                 i_cols,
    input  logic [stcl_pkg::ROW_BITS-1:0]    i_rows,
    output logic                             o_q_push,
    output logic [Q_WIDTH-1:0]               o_q_data,
    input  logic                             i_q_full
);

    localparam int RB = stcl_pkg::ROW_BITS;

    logic signed [SAMPLE_BITS-1:0] r_mem_up [MAX_COLS];
    logic signed [SAMPLE_BITS-1:0] r_mem_lo [MAX_COLS];
    logic signed [SAMPLE_BITS-1:0] r_rd_up;
    logic signed [SAMPLE_BITS-1:0] r_rd_lo;
    logic signed [SAMPLE_BITS-1:0] r_fwd_up;
    logic signed [SAMPLE_BITS-1:0] r_fwd_lo;
    logic                          r_fwd;
    logic signed [SAMPLE_BITS-1:0] r_win [6];

    logic [COL_BITS-1:0]           r_col;
    logic [RB-1:0]                 r_row;

    logic                          r_s1_valid;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;
    logic [COL_BITS-1:0]           r_s1_col;
    logic [RB-1:0]                 r_s1_row;
    logic                          r_s1_prod;
    logic                          r_s1_last;

    logic                          w_accept;
    logic                          w_adv;
    logic [COL_BITS-1:0]           w_c0;
    logic [RB-1:0]                 w_r0;
    logic [COL_BITS-1:0]           w_c;
    logic [RB:0]                   w_r1;
    logic [RB-1:0]                 w_r;
    logic [CNT_W-1:0]              w_c_inc;
    logic [RB:0]                   w_r_inc;
    logic [COL_BITS-1:0]           n_col;
    logic [RB-1:0]                 n_row;
    logic                          w_prod;
    logic                          w_last;
    logic signed [SAMPLE_BITS-1:0] w_up_eff;
    logic signed [SAMPLE_BITS-1:0] w_lo_eff;

    assign w_adv    = r_s1_valid && (!r_s1_prod || !i_q_full);
    assign o_full   = r_s1_valid && !w_adv;
    assign w_accept = i_push && !o_full;
    assign w_up_eff = r_fwd ? r_fwd_up : r_rd_up;
    assign w_lo_eff = r_fwd ? r_fwd_lo : r_rd_lo;

    always_comb begin
        w_c0 = i_frame_start ? '0 : r_col;
        w_r0 = i_frame_start ? '0 : r_row;
        if ({1'b0, w_c0} >= i_cols) begin
            w_c  = '0;
            w_r1 = {1'b0, w_r0} + 1'b1;
        end else begin
            w_c  = w_c0;
            w_r1 = {1'b0, w_r0};
        end
        w_r = (w_r1 >= {1'b0, i_rows}) ? '0 : w_r1[RB-1:0];

        w_c_inc = {1'b0, w_c} + 1'b1;
        w_r_inc = {1'b0, w_r} + 1'b1;
        if (w_c_inc >= i_cols) begin
            n_col = '0;
            n_row = (w_r_inc >= {1'b0, i_rows}) ? '0 : w_r_inc[RB-1:0];
        end else begin
            n_col = w_c_inc[COL_BITS-1:0];
            n_row = w_r;
        end

        w_prod = (w_r >= RB'(2)) && (w_c >= COL_BITS'(2));
        w_last = (w_r == i_rows - 1'b1) && ({1'b0, w_c} == i_cols - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            r_s1_valid <= w_accept || (r_s1_valid && !w_adv);
            if (w_accept) begin
                r_col <= n_col;
                r_row <= n_row;
                r_fwd <= w_adv && (w_c == r_s1_col);
            end
            if (w_adv) begin
                r_win[0] <= r_win[1];
                r_win[1] <= w_up_eff;
                r_win[2] <= r_win[3];
                r_win[3] <= w_lo_eff;
                r_win[4] <= r_win[5];
                r_win[5] <= r_s1_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_sample <= i_sample;
            r_s1_col    <= w_c;
            r_s1_row    <= w_r;
            r_s1_prod   <= w_prod;
            r_s1_last   <= w_last;
            r_fwd_up    <= w_lo_eff;
            r_fwd_lo    <= r_s1_sample;
            r_rd_up     <= r_mem_up[w_c];
            r_rd_lo     <= r_mem_lo[w_c];
        end
        if (w_adv) begin
            r_mem_up[r_s1_col] <= w_lo_eff;
            r_mem_lo[r_s1_col] <= r_s1_sample;
        end
    end

    assign o_q_push = w_adv && r_s1_prod;
    assign o_q_data = {r_s1_last, r_s1_row - 1'b1, r_s1_col - 1'b1,
                       r_s1_sample, r_win[5], r_win[4],
                       w_lo_eff, r_win[3], r_win[2],
                       w_up_eff, r_win[1], r_win[0]};

endmodule

>>> hdl/stcl_back.sv
// Back end: nine mask products, adder tree, round half up, saturation and result register.
module stcl_back #(
    parameter int MAX_COLS       = stcl_pkg::MAX_COLS_DEF,
    parameter int SAMPLE_BITS    = stcl_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = stcl_pkg::COEF_FRAC_BITS_DEF,
    parameter int COL_BITS       = $clog2(MAX_COLS),
    parameter int Q_WIDTH        = stcl_pkg::NUM_TAPS * SAMPLE_BITS + stcl_pkg::ROW_BITS
                                   + COL_BITS + 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  stcl_pkg::t_mask                 i_mask,
    input  logic [Q_WIDTH-1:0]              i_q_data,
    input  logic                            i_q_empty,
    output logic                            o_q_pop,
    output logic                            o_empty,
    input  logic                            i_pop,
    output logic signed [SAMPLE_BITS-1:0]   o_value,
    output logic [stcl_pkg::ROW_BITS-1:0]   o_row_index,
    output logic [COL_BITS-1:0]             o_col_index,
    output logic                            o_frame_last
);

    localparam int CB    = stcl_pkg::COEF_BITS;
    localparam int NT    = stcl_pkg::NUM_TAPS;
    localparam int PW    = SAMPLE_BITS + CB;
    localparam int RW    = PW + 2;
    localparam int AW    = PW + 4;
    localparam int TAG_W = stcl_pkg::ROW_BITS + COL_BITS + 1;
    localparam logic signed [AW-1:0] C_HALF = AW'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [AW-1:0] C_MAX  = (AW'(1) <<< (SAMPLE_BITS - 1)) - AW'(1);
    localparam logic signed [AW-1:0] C_MIN  = -C_MAX - AW'(1);

    logic [stcl_pkg::MASK_BITS-1:0] w_rows [3];
    logic signed [SAMPLE_BITS-1:0]  w_px   [NT];
    logic signed [CB-1:0]           w_coef [NT];
    logic [TAG_W-1:0]               w_tag;

    logic                           w_en;
    logic                           r_v_p;
    logic                           r_v_s1;
    logic                           r_v_s2;
    logic                           r_out_valid;
    logic signed [PW-1:0]           r_prod [NT];
    logic signed [RW-1:0]           r_row_sum [3];
    logic signed [AW-1:0]           r_total;
    logic [TAG_W-1:0]               r_tag_p;
    logic [TAG_W-1:0]               r_tag_s1;
    logic [TAG_W-1:0]               r_tag_s2;
    logic [TAG_W-1:0]               r_out_tag;
    logic signed [SAMPLE_BITS-1:0]  r_out_value;
    logic signed [AW-1:0]           w_q;
    logic signed [SAMPLE_BITS-1:0]  w_sat;

    assign w_rows[0] = i_mask.top;
    assign w_rows[1] = i_mask.middle;
    assign w_rows[2] = i_mask.bottom;
    assign w_tag     = i_q_data[Q_WIDTH-1 -: TAG_W];

    for (genvar j = 0; j < NT; j++) begin : g_tap
        assign w_px[j]   = i_q_data[j*SAMPLE_BITS +: SAMPLE_BITS];
        assign w_coef[j] = w_rows[j / 3][(j % 3) * CB +: CB];
    end

    assign w_en    = !r_out_valid || i_pop;
    assign o_q_pop = w_en && !i_q_empty;
    assign o_empty = !r_out_valid;

    always_comb begin
        w_q = r_total >>> COEF_FRAC_BITS;
        if (w_q > C_MAX) begin
            w_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else if (w_q < C_MIN) begin
            w_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            w_sat = w_q[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_p       <= 1'b0;
            r_v_s1      <= 1'b0;
            r_v_s2      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v_p       <= !i_q_empty;
            r_v_s1      <= r_v_p;
            r_v_s2      <= r_v_s1;
            r_out_valid <= r_v_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < NT; j++) begin
                r_prod[j] <= w_px[j] * w_coef[j];
            end
            for (int i = 0; i < 3; i++) begin
                r_row_sum[i] <= RW'(r_prod[3*i]) + RW'(r_prod[3*i+1]) + RW'(r_prod[3*i+2]);
            end
            r_total     <= AW'(r_row_sum[0]) + AW'(r_row_sum[1]) + AW'(r_row_sum[2])
                           + C_HALF;
            r_out_value <= w_sat;
            r_tag_p     <= w_tag;
            r_tag_s1    <= r_tag_p;
            r_tag_s2    <= r_tag_s1;
            r_out_tag   <= r_tag_s2;
        end
    end

    assign o_value      = r_out_value;
    assign o_frame_last = r_out_tag[TAG_W-1];
    assign o_row_index  = r_out_tag[TAG_W-2 -: stcl_pkg::ROW_BITS];
    assign o_col_index  = r_out_tag[COL_BITS-1:0];

endmodule

>>> bench/stencil_update_checker.sv
`timescale 1ns / 1ps
// Checker that predicts every stencil update from the observed beats and compares the results.
module stencil_update_checker (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          push,
    input  logic                                          full,
    input  logic signed [stcl_pkg::SAMPLE_BITS_DEF-1:0]   i_sample,
    input  logic                                          i_frame_start,
    input  logic                                          empty,
    input  logic                                          pop,
    input  logic signed [stcl_pkg::SAMPLE_BITS_DEF-1:0]   o_value,
    input  logic [stcl_pkg::ROW_BITS-1:0]                 o_row_index,
    input  logic [$clog2(stcl_pkg::MAX_COLS_DEF)-1:0]     o_col_index,
    input  logic                                          o_frame_last,
    input  logic                                          i_cfg_valid,
    input  logic                                          o_cfg_ready,
    input  logic [stcl_pkg::CFG_INDEX_BITS-1:0]           i_cfg_index,
    input  logic [stcl_pkg::MASK_BITS-1:0]                i_cfg_data,
    output int                                            fail_count,
    output int                                            pending_count
);

    localparam int SW       = stcl_pkg::SAMPLE_BITS_DEF;
    localparam int CW       = $clog2(stcl_pkg::MAX_COLS_DEF);
    localparam int RB       = stcl_pkg::ROW_BITS;
    localparam int MB       = stcl_pkg::MASK_BITS;
    localparam int CB       = stcl_pkg::COEF_BITS;
    localparam int NCB      = stcl_pkg::NUM_COLS_BITS;
    localparam int MAX_COLS = stcl_pkg::MAX_COLS_DEF;
    localparam int FRAC     = stcl_pkg::COEF_FRAC_BITS_DEF;
    localparam longint VALUE_MAX = (longint'(1) << (SW - 1)) - 1;
    localparam longint VALUE_MIN = -VALUE_MAX - 1;
    localparam longint ROUND_HALF = longint'(1) << (FRAC - 1);

    typedef struct {
        logic signed [SW-1:0] value;
        logic [RB-1:0]        row;
        logic [CW-1:0]        col;
        logic                 last;
    } t_grid_point;

    logic [NCB-1:0]           cols_reg;
    logic [RB-1:0]            rows_reg;
    stcl_pkg::t_mask          masks;
    logic signed [SW-1:0]     upper_line [MAX_COLS];
    logic signed [SW-1:0]     lower_line [MAX_COLS];
    logic signed [SW-1:0]     window [6];
    int                       cur_row;
    int                       cur_col;
    t_grid_point              expected_points [$];

    function automatic longint mask_coef(logic [MB-1:0] mrow, int k);
        logic signed [CB-1:0] coef;
        coef = mrow[k*CB +: CB];
        return longint'(coef);
    endfunction

    always @(posedge i_clk) begin : predict_and_compare
        int                   eff_cols;
        int                   eff_rows;
        int                   r;
        int                   c;
        logic signed [SW-1:0] column [3];
        logic [MB-1:0]        mrow [3];
        longint               acc;
        t_grid_point          point;
        if (!i_rst_n) begin
            cols_reg = stcl_pkg::NUM_COLS_RST;
            rows_reg = stcl_pkg::NUM_ROWS_RST;
            masks = {stcl_pkg::MASK_TOP_RST, stcl_pkg::MASK_MIDDLE_RST,
                     stcl_pkg::MASK_BOTTOM_RST};
            foreach (window[i]) window[i] = '0;
            cur_row = 0;
            cur_col = 0;
            expected_points.delete();
            fail_count = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    stcl_pkg::CFG_NUM_COLS:    cols_reg = i_cfg_data[NCB-1:0];
                    stcl_pkg::CFG_NUM_ROWS:    rows_reg = i_cfg_data[RB-1:0];
                    stcl_pkg::CFG_MASK_TOP:    masks.top = i_cfg_data;
                    stcl_pkg::CFG_MASK_MIDDLE: masks.middle = i_cfg_data;
                    stcl_pkg::CFG_MASK_BOTTOM: masks.bottom = i_cfg_data;
                    default: ;
                endcase
            end
            if (push && !full) begin
                eff_cols = int'(cols_reg);
                if (eff_cols < 3) eff_cols = 3;
                if (eff_cols > MAX_COLS) eff_cols = MAX_COLS;
                eff_rows = int'(rows_reg);
                if (eff_rows < 3) eff_rows = 3;
                if (i_frame_start) begin
                    cur_row = 0;
                    cur_col = 0;
                end
                if (cur_col >= eff_cols) begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= eff_rows) cur_row = 0;
                r = cur_row;
                c = cur_col;
                column[0] = upper_line[c];
                column[1] = lower_line[c];
                column[2] = i_sample;
                if (r >= 2 && c >= 2) begin
                    mrow[0] = masks.top;
                    mrow[1] = masks.middle;
                    mrow[2] = masks.bottom;
                    acc = 0;
                    for (int i = 0; i < 3; i++) begin
                        acc += mask_coef(mrow[i], 0) * window[2*i]
                             + mask_coef(mrow[i], 1) * window[2*i+1]
                             + mask_coef(mrow[i], 2) * column[i];
                    end
                    acc = (acc + ROUND_HALF) >>> FRAC;
                    if (acc > VALUE_MAX) acc = VALUE_MAX;
                    if (acc < VALUE_MIN) acc = VALUE_MIN;
                    point.value = acc[SW-1:0];
                    point.row = RB'(r - 1);
                    point.col = CW'(c - 1);
                    point.last = (r == eff_rows - 1) && (c == eff_cols - 1);
                    expected_points.push_back(point);
                end
                for (int i = 0; i < 3; i++) begin
                    window[2*i] = window[2*i+1];
                    window[2*i+1] = column[i];
                end
                upper_line[c] = lower_line[c];
                lower_line[c] = i_sample;
                cur_col = c + 1;
                if (cur_col >= eff_cols) begin
                    cur_col = 0;
                    cur_row = r + 1;
                    if (cur_row >= eff_rows) cur_row = 0;
                end
            end
            if (pop && !empty) begin
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected result beat, got value %0d row %0d col %0d last %0b",
                             $time, o_value, o_row_index, o_col_index, o_frame_last);
                    fail_count++;
                end else begin
                    point = expected_points.pop_front();
                    if (o_value !== point.value || o_row_index !== point.row
                            || o_col_index !== point.col || o_frame_last !== point.last) begin
                        $display("%0t: result mismatch, expected value %0d row %0d col %0d last %0b",
                                 $time, point.value, point.row, point.col, point.last);
                        $display("%0t:                   got value %0d row %0d col %0d last %0b",
                                 $time, o_value, o_row_index, o_col_index, o_frame_last);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = expected_points.size();
    end

endmodule

>>> bench/stencil_3x3_grid_update_top_tb.sv
`timescale 1ns / 1ps
// Testbench top that streams grid samples and register writes into the stencil block.
module stencil_3x3_grid_update_top_tb;

    localparam int SW = stcl_pkg::SAMPLE_BITS_DEF;
    localparam int CW = $clog2(stcl_pkg::MAX_COLS_DEF);
    localparam int CB = stcl_pkg::COEF_BITS;
    localparam int MB = stcl_pkg::MASK_BITS;
    localparam int RB = stcl_pkg::ROW_BITS;
    localparam int NCB = stcl_pkg::NUM_COLS_BITS;
    localparam int IB = stcl_pkg::CFG_INDEX_BITS;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_ITEMS = 800;
    localparam int FILL_COLS = 40;

    typedef logic signed [SW-1:0] t_sample;

    localparam t_sample SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam t_sample SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [CB-1:0] COEF_MAX = 16'h7FFF;
    localparam logic [CB-1:0] COEF_MIN = 16'h8000;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        push = 1'b0;
    logic                        full;
    t_sample                     i_sample = '0;
    logic                        i_frame_start = 1'b0;
    logic                        empty;
    logic                        pop = 1'b0;
    t_sample                     o_value;
    logic [RB-1:0]               o_row_index;
    logic [CW-1:0]               o_col_index;
    logic                        o_frame_last;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [IB-1:0]               i_cfg_index = '0;
    logic [MB-1:0]               i_cfg_data = '0;
    int                          fail_count;
    int                          pending_count;
    int                          idle_cycles = 0;
    int                          stall_left = 0;
    bit                          send_gaps = 1'b1;
    bit                          pop_stalls = 1'b1;

    stencil_3x3_grid_update_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_sample      (i_sample),
        .i_frame_start (i_frame_start),
        .empty         (empty),
        .pop           (pop),
        .o_value       (o_value),
        .o_row_index   (o_row_index),
        .o_col_index   (o_col_index),
        .o_frame_last  (o_frame_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    stencil_update_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_sample      (i_sample),
        .i_frame_start (i_frame_start),
        .empty         (empty),
        .pop           (pop),
        .o_value       (o_value),
        .o_row_index   (o_row_index),
        .o_col_index   (o_col_index),
        .o_frame_last  (o_frame_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int gap_length();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_sample random_sample();
        case ($urandom_range(0, 3))
            0: return t_sample'($urandom);
            1: return t_sample'(int'($urandom_range(0, 65535)) - 32768);
            2: return t_sample'(int'($urandom_range(0, 2097151)) - 1048576);
            default: begin
                case ($urandom_range(0, 3))
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    function automatic stcl_pkg::t_mask random_mask();
        logic [3*MB-1:0]  bits;
        logic [CB-1:0]    extremes [4];
        logic [CB-1:0]    fill;
        int unsigned      mode;
        mode = $urandom_range(0, 3);
        extremes = '{COEF_MAX, COEF_MIN, '0, '1};
        fill = $urandom_range(0, 1) ? '0 : '1;
        for (int k = 0; k < 9; k++) begin
            case (mode)
                0: bits[k*CB +: CB] = CB'($urandom);
                1: bits[k*CB +: CB] = CB'(int'($urandom_range(0, 8192)) - 4096);
                2: bits[k*CB +: CB] = extremes[$urandom_range(0, 3)];
                default: bits[k*CB +: CB] = fill;
            endcase
        end
        return bits;
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (pop_stalls && $urandom_range(0, 99) < 15) begin
            pop <= 1'b0;
            stall_left <= gap_length() - 1;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input logic [IB-1:0] index, input logic [MB-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic apply_settings(input bit [4:0] which, input bit bogus,
                                  input logic [NCB-1:0] cols,
                                  input logic [RB-1:0] rows, input stcl_pkg::t_mask masks);
        logic [MB-1:0] noise;
        noise = MB'({$urandom, $urandom});
        if (which[stcl_pkg::CFG_NUM_COLS])
            write_reg(stcl_pkg::CFG_NUM_COLS, {noise[MB-1:NCB], cols});
        if (which[stcl_pkg::CFG_NUM_ROWS])
            write_reg(stcl_pkg::CFG_NUM_ROWS, {noise[MB-1:RB], rows});
        if (which[stcl_pkg::CFG_MASK_TOP])
            write_reg(stcl_pkg::CFG_MASK_TOP, masks.top);
        if (which[stcl_pkg::CFG_MASK_MIDDLE])
            write_reg(stcl_pkg::CFG_MASK_MIDDLE, masks.middle);
        if (which[stcl_pkg::CFG_MASK_BOTTOM])
            write_reg(stcl_pkg::CFG_MASK_BOTTOM, masks.bottom);
        if (bogus)
            write_reg(IB'(stcl_pkg::CFG_MASK_BOTTOM + $urandom_range(1, 3)), noise);
        if (which != '0 || bogus) i_cfg_valid <= 1'b0;
    endtask

    task automatic send(input t_sample sample, input bit frame_start);
        if (send_gaps && $urandom_range(0, 99) < 20) begin
            push <= 1'b0;
            repeat (gap_length()) @(posedge i_clk);
        end
        push <= 1'b1;
        i_sample <= sample;
        i_frame_start <= frame_start;
        do @(posedge i_clk); while (full);
    endtask

    task automatic stream(input int count, input bit restart, input bit stray_starts);
        for (int i = 0; i < count; i++)
            send(random_sample(), (i == 0 && restart)
                                  || (stray_starts && $urandom_range(0, 49) == 0));
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        do @(negedge i_clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [NCB-1:0] cols;
        logic [RB-1:0]  rows;
        int             random_sent;
        int             count;
        random_sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Smallest grid with saturating coefficients, then a wrap and a restarted frame.
        apply_settings(5'b11111, 1'b1, '0, 16'd2, {9{COEF_MAX}});
        for (int i = 0; i < 9; i++) send(SAMPLE_MAX, i == 0);
        for (int i = 0; i < 4; i++) send(SAMPLE_MIN, 1'b0);
        for (int i = 0; i < 9; i++) send(SAMPLE_MIN, i == 0);
        wait_idle();

        // One frame at the widest random row writes every line store entry used later.
        apply_settings(5'b11111, 1'b0, NCB'(FILL_COLS), 16'd3,
                       {stcl_pkg::MASK_TOP_RST, stcl_pkg::MASK_MIDDLE_RST,
                        stcl_pkg::MASK_BOTTOM_RST});
        stream(3 * FILL_COLS, 1'b1, 1'b0);

        while (random_sent < RANDOM_ITEMS) begin
            wait_idle();
            case ($urandom_range(0, 9))
                0: cols = NCB'($urandom_range(0, 2));
                1: cols = NCB'($urandom_range(13, FILL_COLS));
                default: cols = NCB'($urandom_range(3, 12));
            endcase
            case ($urandom_range(0, 9))
                0: rows = RB'($urandom_range(0, 2));
                1: rows = RB'($urandom_range(9, 65535));
                2: rows = '1;
                default: rows = RB'($urandom_range(3, 8));
            endcase
            apply_settings(5'($urandom_range(0, 31)), $urandom_range(0, 4) == 0,
                           cols, rows, random_mask());
            send_gaps = $urandom_range(0, 3) != 0;
            pop_stalls = $urandom_range(0, 3) != 0;
            count = $urandom_range(20, 80);
            stream(count, $urandom_range(0, 3) != 0, 1'b1);
            random_sent += count;
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/stcl_pkg.sv
hdl/stcl_fifo.sv
hdl/stcl_front.sv
hdl/stcl_back.sv
hdl/stencil_3x3_grid_update_top.sv
bench/stencil_update_checker.sv
bench/stencil_3x3_grid_update_top_tb.sv
